// ----- rtl/ipv4p_pkg.sv -----
// Package for the IPv4 dotted-text parser: transaction structs, part state,
// phase and radix codes, and character constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

  // Default limit on the text length in characters
  localparam int MAX_TEXT_LENGTH_DEF = 15;

  // Part phases
  localparam logic [2:0] PH_EMPTY  = 3'd0;  // nothing since the last dot
  localparam logic [2:0] PH_BLANKS = 3'd1;  // blanks only
  localparam logic [2:0] PH_SIGN   = 3'd2;  // sign seen, no digit yet
  localparam logic [2:0] PH_ZERO   = 3'd3;  // leading zero seen
  localparam logic [2:0] PH_XSEEN  = 3'd4;  // "0x" seen
  localparam logic [2:0] PH_DIGITS = 3'd5;  // reading digits
  localparam logic [2:0] PH_DONE   = 3'd6;  // rest of part ignored

  // Radix codes
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // Part value saturation point and limits
  localparam logic [8:0] PART_SAT   = 9'd256;
  localparam logic [8:0] PART_MAX   = 9'd255;
  localparam logic [2:0] COUNT_SAT  = 3'd5;
  localparam logic [2:0] COUNT_GOOD = 3'd4;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } ipv4p_in_t;

  typedef struct packed {
    logic [31:0] address;
    logic        valid_res;
  } ipv4p_out_t;

  // Parser state apart from the text length
  typedef struct packed {
    logic [31:0] acc;
    logic [8:0]  value;
    logic [2:0]  phase;
    logic [1:0]  radix;
    logic        negative;
    logic [2:0]  count;
    logic        failed;
  } ipv4p_state_t;

  localparam ipv4p_state_t STATE_RESET = '{
    acc: 32'd0, value: 9'd0, phase: PH_EMPTY, radix: RX_DEC,
    negative: 1'b0, count: 3'd0, failed: 1'b0
  };

endpackage

`default_nettype wire

// ----- rtl/ipv4p_step.sv -----
// Combinational next-state logic of the parser for one transaction.
// Depends on ipv4p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_step #(
  parameter int MAX_TEXT_LENGTH = ipv4p_pkg::MAX_TEXT_LENGTH_DEF,
  parameter int LEN_W = $clog2(MAX_TEXT_LENGTH + 2)
) (
  input  ipv4p_pkg::ipv4p_in_t    item,
  input  ipv4p_pkg::ipv4p_state_t st,
  input  logic [LEN_W-1:0]        len,
  output ipv4p_pkg::ipv4p_state_t st_next,
  output logic [LEN_W-1:0]        len_next,
  output ipv4p_pkg::ipv4p_out_t   res
);
  import ipv4p_pkg::*;

  // Multiply-accumulate by the radix, saturating at 256
  function automatic logic [8:0] add_digit(logic [8:0] v, logic [3:0] d, logic [1:0] rx);
    logic [12:0] prod;
    unique case (rx)
      RX_HEX:  prod = {v, 4'b0000};
      RX_OCT:  prod = {1'b0, v, 3'b000};
      default: prod = {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
    endcase
    prod = prod + {9'd0, d};
    return (prod > 13'(PART_SAT)) ? PART_SAT : prod[8:0];
  endfunction

  // Close the current part and clear it
  function automatic ipv4p_state_t finish_part(ipv4p_state_t s);
    ipv4p_state_t r;
    r = s;
    if (s.phase != PH_EMPTY && s.count < COUNT_SAT) begin
      if (s.value > PART_MAX || (s.negative && s.value != 9'd0)) begin
        r.failed = 1'b1;
      end else begin
        r.acc = {s.acc[23:0], s.value[7:0]};
      end
      r.count = s.count + 3'd1;
    end
    r.value    = 9'd0;
    r.phase    = PH_EMPTY;
    r.radix    = RX_DEC;
    r.negative = 1'b0;
    return r;
  endfunction

  logic [7:0]   c;
  logic [4:0]   hexd;
  logic         is_blank;
  logic         ok_dec;
  logic         ok_oct;
  logic         ok_hex;
  logic         ok_cur;
  ipv4p_state_t fin;
  logic         good;

  assign c = item.text_char;

  // Character classification
  always_comb begin
    hexd = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      hexd = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hexd = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hexd = 5'(c - 8'h37);
    end
    is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    ok_dec   = hexd < 5'd10;
    ok_oct   = hexd < 5'd8;
    ok_hex   = hexd < 5'd16;
    unique case (st.radix)
      RX_HEX:  ok_cur = ok_hex;
      RX_OCT:  ok_cur = ok_oct;
      default: ok_cur = ok_dec;
    endcase
  end

  // State update and result
  always_comb begin
    fin      = finish_part(st);
    st_next  = st;
    len_next = len;
    good     = !fin.failed && fin.count == COUNT_GOOD && len <= LEN_W'(MAX_TEXT_LENGTH);
    res.address   = good ? fin.acc : 32'd0;
    res.valid_res = good;
    if (item.end_of_text) begin
      st_next  = STATE_RESET;
      len_next = '0;
    end else begin
      if (len <= LEN_W'(MAX_TEXT_LENGTH)) begin
        len_next = len + LEN_W'(1);
      end
      if (c == CH_DOT) begin
        st_next = fin;
      end else begin
        unique case (st.phase) inside
          PH_EMPTY, PH_BLANKS, PH_SIGN: begin
            if (st.phase != PH_SIGN && is_blank) begin
              st_next.phase = PH_BLANKS;
            end else if (st.phase != PH_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
              st_next.negative = (c == CH_MINUS);
              st_next.phase    = PH_SIGN;
            end else if (c == CH_ZERO) begin
              st_next.phase = PH_ZERO;
            end else if (ok_dec) begin
              st_next.radix = RX_DEC;
              st_next.value = {5'd0, hexd[3:0]};
              st_next.phase = PH_DIGITS;
            end else begin
              st_next.phase = PH_DONE;
            end
          end
          PH_ZERO: begin
            if (c == CH_X_LO || c == CH_X_UP) begin
              st_next.phase = PH_XSEEN;
            end else begin
              st_next.radix = RX_OCT;
              if (ok_oct) begin
                st_next.value = add_digit(st.value, hexd[3:0], RX_OCT);
                st_next.phase = PH_DIGITS;
              end else begin
                st_next.phase = PH_DONE;
              end
            end
          end
          PH_XSEEN: begin
            st_next.radix = RX_HEX;
            if (ok_hex) begin
              st_next.value = add_digit(st.value, hexd[3:0], RX_HEX);
              st_next.phase = PH_DIGITS;
            end else begin
              st_next.phase = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (ok_cur) begin
              st_next.value = add_digit(st.value, hexd[3:0], st.radix);
            end else begin
              st_next.phase = PH_DONE;
            end
          end
          default: begin
            st_next = st;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ipv4_dotted_text_parser_unit.sv -----
// IPv4 dotted-text parser, top level; uses ipv4p_pkg and ipv4p_step.
// An accepted end item passes through the input register and then, once the output
// has room, into the result register. Throughput: one transaction per cycle unless an
// end item is held by a full output; set by the combinational state update between the input and result registers.
// Reset (rst, synchronous): parser state cleared, both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_text_parser_unit #(
  parameter int MAX_TEXT_LENGTH = ipv4p_pkg::MAX_TEXT_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipv4p_pkg::ipv4p_in_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipv4p_pkg::ipv4p_out_t out_item
);
  import ipv4p_pkg::*;

  localparam int LEN_W = $clog2(MAX_TEXT_LENGTH + 2);

  logic             held;
  ipv4p_in_t        in_reg;
  ipv4p_state_t     state;
  ipv4p_state_t     state_next;
  logic [LEN_W-1:0] text_length;
  logic [LEN_W-1:0] text_length_next;
  ipv4p_out_t       res;
  logic             proc;

  // Held item advances unless it is an end item blocked by a full output
  assign proc     = held && (!in_reg.end_of_text || !out_valid || out_ready);
  assign in_ready = !held || proc;

  ipv4p_step #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH),
    .LEN_W(LEN_W)
  ) u_step (
    .item(in_reg),
    .st(state),
    .len(text_length),
    .st_next(state_next),
    .len_next(text_length_next),
    .res(res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_reg <= in_item;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= STATE_RESET;
      text_length <= '0;
    end else if (proc) begin
      state       <= state_next;
      text_length <= text_length_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && in_reg.end_of_text) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (proc && in_reg.end_of_text) begin
      out_item <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.valid_res |-> out_item.address == 32'd0)
    else $error("invalid result carries a nonzero address");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    proc && in_reg.end_of_text |=> state.count == 3'd0 && text_length == '0 && !state.failed)
    else $error("parser state not cleared after end item");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    state.count <= COUNT_SAT)
    else $error("part count beyond saturation");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    held && !proc |=> held && $stable(in_reg))
    else $error("stalled input register changed");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_ipv4_dotted_text_parser_unit.sv -----
// Testbench for ipv4_dotted_text_parser_unit: streams address text one character per
// transaction and checks each parsed address against an in-bench parser model.
// Depends on ipv4p_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_ipv4_dotted_text_parser_unit;
  import ipv4p_pkg::*;

  localparam int TEXT_LIMIT   = MAX_TEXT_LENGTH_DEF;
  localparam int ITEM_TARGET  = 500;
  localparam int IDLE_PCT     = 35;
  localparam int QUIET_FROM   = 700;
  localparam int QUIET_TO     = 1000;
  localparam int STALL_CYCLES = 250;
  localparam int BURST_ENDS   = 40;
  localparam int SETTLE       = 10;
  localparam logic [4:0] NO_DIGIT = 5'd16;

  typedef enum logic [1:0] {STIM_CHAR, STIM_DRAIN, STIM_STALL} stim_kind_e;
  typedef struct packed {
    stim_kind_e kind;
    ipv4p_in_t  item;
  } stim_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  ipv4p_in_t  in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  ipv4p_out_t out_item;

  stim_t       feed[$];
  logic [7:0]  draft[$];
  ipv4p_out_t  awaited_addrs[$];
  int          mismatches    = 0;
  int          cyc           = 0;
  int          items_queued  = 0;
  logic        stall_trigger = 1'b0;
  logic        stall_used    = 1'b0;
  int          stall_left    = 0;

  string      odd_parts[12] = '{"", " ", "+", "-", "-0", "0x", "0X", "00", "08", "0x1g",
                                "9a", "-00"};
  string      noise_set     = "0123456789.xX+- aF";
  logic [7:0] blanks[6]     = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

  // Mirror of the parser state
  logic [31:0] addr_acc     = '0;
  logic [8:0]  part_val     = '0;
  logic [2:0]  part_ph      = PH_EMPTY;
  logic [1:0]  part_rx      = RX_DEC;
  logic        part_neg     = 1'b0;
  logic [2:0]  parts_seen   = '0;
  logic [4:0]  text_len     = '0;
  logic        parse_failed = 1'b0;

  ipv4_dotted_text_parser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Closes the current part: empty parts are skipped, count saturates at five
  function automatic void close_part();
    if (part_ph != PH_EMPTY && parts_seen < COUNT_SAT) begin
      if (part_val > PART_MAX || (part_neg && part_val != '0)) begin
        parse_failed = 1'b1;
      end else begin
        addr_acc = {addr_acc[23:0], part_val[7:0]};
      end
      parts_seen = parts_seen + 3'd1;
    end
    part_val = '0;
    part_ph  = PH_EMPTY;
    part_rx  = RX_DEC;
    part_neg = 1'b0;
  endfunction

  // Advances the parser model by one accepted transaction
  function automatic void parse_step(ipv4p_in_t it);
    logic [7:0] c;
    logic [4:0] d;
    logic       to_digits;
    logic       ok;
    int         base;
    int         v;
    ipv4p_out_t res;
    c = it.text_char;
    to_digits = 1'b0;
    if (it.end_of_text) begin
      close_part();
      ok = !parse_failed && parts_seen == COUNT_GOOD && text_len <= TEXT_LIMIT;
      res.address   = ok ? addr_acc : '0;
      res.valid_res = ok;
      awaited_addrs.push_back(res);
      addr_acc     = '0;
      parts_seen   = '0;
      text_len     = '0;
      parse_failed = 1'b0;
    end else begin
      if (text_len <= TEXT_LIMIT) text_len = text_len + 5'd1;
      if (c == CH_DOT) begin
        close_part();
      end else begin
        case (part_ph) inside
          PH_EMPTY, PH_BLANKS, PH_SIGN: begin
            if (part_ph != PH_SIGN && (c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
              part_ph = PH_BLANKS;
            end else if (part_ph != PH_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
              part_neg = (c == CH_MINUS);
              part_ph  = PH_SIGN;
            end else if (c == CH_ZERO) begin
              part_ph = PH_ZERO;
            end else begin
              to_digits = 1'b1;  // radix still decimal here
            end
          end
          PH_ZERO: begin
            if (c == CH_X_LO || c == CH_X_UP) begin
              part_ph = PH_XSEEN;
            end else begin
              part_rx   = RX_OCT;
              to_digits = 1'b1;
            end
          end
          PH_XSEEN: begin
            part_rx   = RX_HEX;
            to_digits = 1'b1;
          end
          PH_DIGITS: to_digits = 1'b1;
          default: ;
        endcase
        // Digit in the current radix, else the part stops here
        if (to_digits) begin
          d = NO_DIGIT;
          if (c >= "0" && c <= "9") d = 5'(c - "0");
          else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
          else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
          if (part_rx == RX_OCT && d > 5'd7) d = NO_DIGIT;
          if (part_rx == RX_DEC && d > 5'd9) d = NO_DIGIT;
          if (d == NO_DIGIT) begin
            part_ph = PH_DONE;
          end else begin
            base = (part_rx == RX_HEX) ? 16 : ((part_rx == RX_OCT) ? 8 : 10);
            v = int'(part_val) * base + int'(d);
            part_val = (v > int'(PART_SAT)) ? PART_SAT : 9'(v);
            part_ph  = PH_DIGITS;
          end
        end
      end
    end
  endfunction

  // Stimulus building
  task automatic draft_str(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  task automatic queue_text();
    stim_t s;
    s.kind = STIM_CHAR;
    foreach (draft[i]) begin
      s.item.text_char   = draft[i];
      s.item.end_of_text = 1'b0;
      feed.push_back(s);
    end
    s.item.text_char   = 8'($urandom_range(0, 255));
    s.item.end_of_text = 1'b1;
    feed.push_back(s);
    items_queued += draft.size() + 1;
    draft.delete();
  endtask

  task automatic push_marker(stim_kind_e k);
    stim_t s;
    s      = '0;
    s.kind = k;
    feed.push_back(s);
  endtask

  // One random part: decimal, octal, hex or an odd form, with optional blank/sign/junk
  task automatic add_part();
    int    style;
    int    mag;
    int    v;
    string s;
    style = $urandom_range(0, 19);
    mag   = $urandom_range(0, 2);
    v = (mag == 0) ? $urandom_range(0, 9) : ((mag == 1) ? $urandom_range(0, 99)
                                                        : $urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) v = $urandom_range(256, 600);
    if ($urandom_range(0, 9) == 0) draft.push_back(blanks[$urandom_range(0, 5)]);
    if ($urandom_range(0, 9) == 0) draft.push_back(($urandom_range(0, 3) == 0) ? CH_MINUS
                                                                             : CH_PLUS);
    if (style < 13) begin
      draft_str($sformatf("%0d", v));
    end else if (style < 16) begin
      draft_str($sformatf("0%0o", v));
    end else if (style < 19) begin
      draft.push_back(CH_ZERO);
      draft.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
      s = $sformatf("%0h", v);
      for (int i = 0; i < s.len(); i++) begin
        if (s[i] >= "a" && $urandom_range(0, 1)) draft.push_back(s[i] - 8'd32);
        else draft.push_back(s[i]);
      end
    end else begin
      draft_str(odd_parts[$urandom_range(0, 11)]);
    end
    if ($urandom_range(0, 9) == 0) draft.push_back(8'($urandom_range(33, 126)));
  endtask

  // Free-running cycle count
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Sender: one character transaction per cycle at most, random gaps
  always @(posedge clk) begin : char_driver
    logic idle;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_step(in_item);
      if (!in_valid || in_ready) begin
        while (feed.size() > 0 && feed[0].kind != STIM_CHAR &&
               (feed[0].kind == STIM_STALL || awaited_addrs.size() == 0)) begin
          if (feed[0].kind == STIM_STALL) stall_trigger <= 1'b1;
          void'(feed.pop_front());
        end
        idle = !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(0, 99) < IDLE_PCT);
        if (feed.size() > 0 && feed[0].kind == STIM_CHAR && !idle) begin
          in_item  <= feed[0].item;
          in_valid <= 1'b1;
          void'(feed.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each result, random back-pressure plus one long hold-off
  always @(posedge clk) begin : result_monitor
    ipv4p_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_addrs.size() == 0) begin
          $error("unexpected result: address %h valid_res %b",
                 out_item.address, out_item.valid_res);
          mismatches++;
        end else begin
          want = awaited_addrs.pop_front();
          if (out_item.address !== want.address) begin
            $error("address: expected %h, got %h", want.address, out_item.address);
            mismatches++;
          end
          if (out_item.valid_res !== want.valid_res) begin
            $error("valid_res: expected %b, got %b", want.valid_res, out_item.valid_res);
            mismatches++;
          end
        end
      end
      if (stall_trigger && !stall_used) begin
        stall_used = 1'b1;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (cyc >= QUIET_FROM && cyc < QUIET_TO) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int stop_at;
    int r;
    int parts;
    int n;
    bit mid_drain;
    mid_drain = 1'b0;

    // Directed texts: empty text; hex, negative zero, blank-only part and octal;
    // sign-only part, bare 0x and an oversized part; code zero and 0xFF as stray
    // characters; the longest legal text with the top address
    queue_text();
    draft_str("0xff.-0. .0377");
    queue_text();
    draft_str("+.0x.256.9");
    queue_text();
    draft_str("1");
    draft.push_back(8'hFF);
    draft_str(".2.3");
    draft.push_back(8'h00);
    draft_str(".4");
    queue_text();
    draft_str("255.255.255.255");
    queue_text();

    // Let the pipe empty, then a burst of end items against a stalled receiver
    push_marker(STIM_DRAIN);
    push_marker(STIM_STALL);
    repeat (BURST_ENDS) queue_text();

    // Random texts: mostly four-part addresses, some wrong counts, some noise
    stop_at = ITEM_TARGET;
    while (items_queued < stop_at) begin
      if (!mid_drain && items_queued > stop_at - ITEM_TARGET / 2) begin
        push_marker(STIM_DRAIN);
        mid_drain = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 82) begin
        parts = (r < 70) ? 4 : ($urandom_range(0, 1) ? 3 : 5);
        for (int p = 0; p < parts; p++) begin
          if (p > 0) draft.push_back(CH_DOT);
          if ($urandom_range(0, 19) == 0) draft.push_back(CH_DOT);
          add_part();
        end
      end else begin
        n = $urandom_range(0, 18);
        repeat (n) begin
          if ($urandom_range(0, 1)) draft.push_back(noise_set[$urandom_range(0, 17)]);
          else draft.push_back(8'($urandom_range(0, 255)));
        end
      end
      queue_text();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (feed.size() != 0 || in_valid || awaited_addrs.size() != 0);
    repeat (SETTLE) @(negedge clk);

    if (mismatches == 0 && awaited_addrs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
